[rtl/crm_pkg.sv]
// Shared types, constants and codes for the crash response monitor.
package crm_pkg;

    localparam int TIME_BITS = 32;

    // Item kinds
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_IMPACT  = 2'd1;
    localparam logic [1:0] CMD_HEADING = 2'd2;

    // Report codes
    localparam logic [1:0] LVL_NONE   = 2'd0;
    localparam logic [1:0] LVL_CRASH  = 2'd2;
    localparam logic [1:0] LVL_SEVERE = 2'd3;
    localparam logic [1:0] LAMP_NONE  = 2'd0;
    localparam logic [1:0] LAMP_CRASH = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_SWING_THRESH = 2'd0;
    localparam logic [1:0] REG_COOLDOWN     = 2'd1;
    localparam logic [1:0] REG_WINDOW       = 2'd2;

    localparam logic [7:0]  RST_SWING_THRESH = 8'd30;
    localparam logic [15:0] RST_COOLDOWN     = 16'd1000;
    localparam logic [15:0] RST_WINDOW       = 16'd1000;

    // Heading reduction: q = (raw * MOD_RECIP) >> MOD_SHIFT is floor(raw / 360) or one less
    localparam logic [8:0]  DEG_FULL  = 9'd360;
    localparam logic [7:0]  DEG_HALF  = 8'd180;
    localparam logic [15:0] MOD_RECIP = 16'd46603;
    localparam int          MOD_SHIFT = 24;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] heading;
    } t_in_item;

    typedef struct packed {
        logic [1:0] accident_level;
        logic [1:0] lamp_level;
        logic       crash_ignored;
        logic       watching;
        logic [7:0] largest_swing;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  swing_thresh_deg;
        logic [15:0] cooldown_ms;
        logic [15:0] window_ms;
    } t_cfg;

endpackage

[rtl/crm_core.sv]
// Monitor state and per-item update: cooldown, watch window, swing tracking.
module crm_core import crm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_cmd,
    input  logic [8:0] i_hdg,
    input  t_cfg       i_cfg,
    output t_out_item  o_res
);

    logic [TIME_BITS-1:0] r_time, n_time;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [TIME_BITS-1:0] r_wstart, n_wstart;
    logic                 r_crashed, n_crashed;
    logic [8:0]           r_cur, n_cur;
    logic [8:0]           r_base, n_base;
    logic [7:0]           r_swing, n_swing;
    logic                 r_wopen, n_wopen;
    logic                 r_severe, n_severe;
    logic                 r_pending, n_pending;

    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] since_now;
    logic [TIME_BITS-1:0] since_tick;
    logic [TIME_BITS-1:0] elapsed_tick;
    logic [TIME_BITS-1:0] cooldown_ext;
    logic [TIME_BITS-1:0] window_ext;
    logic                 block_now;
    logic                 block_tick;
    logic [8:0]           diff_raw;
    logic [8:0]           diff_wrap;
    logic [7:0]           swing_new;

    assign time_inc     = r_time + TIME_BITS'(1);
    assign since_now    = r_time - r_last;
    assign since_tick   = since_now + TIME_BITS'(1);
    assign elapsed_tick = time_inc - r_wstart;
    assign cooldown_ext = TIME_BITS'(i_cfg.cooldown_ms);
    assign window_ext   = TIME_BITS'(i_cfg.window_ms);
    assign block_now    = r_crashed && (since_now < cooldown_ext);
    assign block_tick   = r_crashed && (since_tick < cooldown_ext);

    // Wrapped angle between base and new heading, always 0..180
    assign diff_raw  = (r_base > i_hdg) ? (r_base - i_hdg) : (i_hdg - r_base);
    assign diff_wrap = (diff_raw > 9'(DEG_HALF)) ? (DEG_FULL - diff_raw) : diff_raw;
    assign swing_new = (diff_wrap[7:0] > r_swing) ? diff_wrap[7:0] : r_swing;

    always_comb begin
        n_time    = r_time;
        n_last    = r_last;
        n_wstart  = r_wstart;
        n_crashed = r_crashed;
        n_cur     = r_cur;
        n_base    = r_base;
        n_swing   = r_swing;
        n_wopen   = r_wopen;
        n_severe  = r_severe;
        n_pending = r_pending;
        o_res.accident_level = LVL_NONE;
        o_res.lamp_level     = LAMP_NONE;
        o_res.crash_ignored  = 1'b0;

        case (i_cmd)
            CMD_TICK: begin
                n_time = time_inc;
                if (r_wopen) begin
                    if (elapsed_tick >= window_ext) begin
                        n_wopen = 1'b0;
                        // Serve the held impact at the closing tick
                        if (r_pending) begin
                            n_pending = 1'b0;
                            if (block_tick) begin
                                o_res.crash_ignored = 1'b1;
                            end else begin
                                n_last    = time_inc;
                                n_wstart  = time_inc;
                                n_crashed = 1'b1;
                                n_wopen   = 1'b1;
                                n_base    = r_cur;
                                n_swing   = '0;
                                n_severe  = 1'b0;
                                o_res.accident_level = LVL_CRASH;
                                o_res.lamp_level     = LAMP_CRASH;
                            end
                        end
                    end else if (!r_severe && (r_swing >= i_cfg.swing_thresh_deg)) begin
                        n_severe = 1'b1;
                        o_res.accident_level = LVL_SEVERE;
                        o_res.lamp_level     = LAMP_CRASH;
                    end
                end
            end
            CMD_IMPACT: begin
                if (r_wopen) begin
                    n_pending = 1'b1;
                end else if (block_now) begin
                    o_res.crash_ignored = 1'b1;
                end else begin
                    n_last    = r_time;
                    n_wstart  = r_time;
                    n_crashed = 1'b1;
                    n_wopen   = 1'b1;
                    n_base    = r_cur;
                    n_swing   = '0;
                    n_severe  = 1'b0;
                    o_res.accident_level = LVL_CRASH;
                    o_res.lamp_level     = LAMP_CRASH;
                end
            end
            CMD_HEADING: begin
                n_cur = i_hdg;
                if (r_wopen) begin
                    n_swing = swing_new;
                    if (!r_severe && (swing_new >= i_cfg.swing_thresh_deg)) begin
                        n_severe = 1'b1;
                        o_res.accident_level = LVL_SEVERE;
                        o_res.lamp_level     = LAMP_CRASH;
                    end
                end
            end
            default: begin
                // unused code: no time passes, report status only
            end
        endcase

        o_res.watching      = n_wopen;
        o_res.largest_swing = n_swing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_last    <= '0;
            r_wstart  <= '0;
            r_crashed <= 1'b0;
            r_cur     <= '0;
            r_base    <= '0;
            r_swing   <= '0;
            r_wopen   <= 1'b0;
            r_severe  <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_time    <= n_time;
            r_last    <= n_last;
            r_wstart  <= n_wstart;
            r_crashed <= n_crashed;
            r_cur     <= n_cur;
            r_base    <= n_base;
            r_swing   <= n_swing;
            r_wopen   <= n_wopen;
            r_severe  <= n_severe;
            r_pending <= n_pending;
        end
    end

endmodule

[rtl/crash_response_monitor.sv]
// Top level of the crash response monitor: heading reduction pipeline, state, result register.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+------------------------------
//  input    | i_in_valid   | o_in_ready   | i_in  (t_in_item)
//  result   | o_out_valid  | i_out_ready  | o_out (t_out_item)
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while results are taken; its result reaches the result
//  register through the pipeline (quotient estimate into the input stage, remainder into the
//  second stage, then the state update into the result register).
//  Empty stages fill while the result register waits, so up to three requests stay in flight.
//  Reset is synchronous: all monitor state clears, registers return to 30 / 1000 / 1000.
//  Config writes are always taken.
module crash_response_monitor import crm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_s1_v;
    logic [1:0] r_s1_cmd;
    logic [15:0] r_s1_raw;
    logic [7:0] r_s1_q;
    logic       r_s2_v;
    logic [1:0] r_s2_cmd;
    logic [8:0] r_s2_hdg;
    logic       r_out_v;
    t_out_item  r_out;

    logic        out_load;
    logic        s2_load;
    logic        s1_load;
    logic        fire;
    logic [31:0] q_prod;
    logic [16:0] q_times;
    logic [16:0] rem_raw;
    logic [8:0]  rem_fix;
    t_out_item   core_res;

    assign out_load   = !r_out_v || i_out_ready;
    assign fire       = r_s2_v && out_load;
    assign s2_load    = !r_s2_v || out_load;
    assign s1_load    = !r_s1_v || s2_load;
    assign o_in_ready = s1_load;
    assign o_cfg_ready = 1'b1;

    // Quotient estimate, at most one below floor(raw / 360)
    assign q_prod  = 32'(i_in.heading) * 32'(MOD_RECIP);
    assign q_times = 17'(r_s1_q) * 17'(DEG_FULL);
    assign rem_raw = {1'b0, r_s1_raw} - q_times;
    assign rem_fix = (rem_raw >= 17'(DEG_FULL)) ? 9'(rem_raw - 17'(DEG_FULL)) : rem_raw[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swing_thresh_deg <= RST_SWING_THRESH;
            r_cfg.cooldown_ms      <= RST_COOLDOWN;
            r_cfg.window_ms        <= RST_WINDOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SWING_THRESH: r_cfg.swing_thresh_deg <= i_cfg_data[7:0];
                REG_COOLDOWN:     r_cfg.cooldown_ms      <= i_cfg_data;
                REG_WINDOW:       r_cfg.window_ms        <= i_cfg_data;
                default: begin
                    // drop writes to unmapped index
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_v <= i_in_valid;
            end
            if (s2_load) begin
                r_s2_v <= r_s1_v;
            end
            if (out_load) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_cmd <= i_in.cmd;
            r_s1_raw <= i_in.heading;
            r_s1_q   <= q_prod[MOD_SHIFT +: 8];
        end
        if (s2_load) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_hdg <= rem_fix;
        end
        if (fire) begin
            r_out <= core_res;
        end
    end

    crm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_s2_cmd),
        .i_hdg   (r_s2_hdg),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

[rtl/crm_checker.sv]
// Port-level checks for the crash response monitor, bound to the top level.
module crm_checker import crm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // A fresh crash opens the window with the swing cleared
    a_crash_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.accident_level == LVL_CRASH |->
            o_out.watching && o_out.largest_swing == 8'd0 && o_out.lamp_level == LAMP_CRASH)
        else $error("crash report without fresh window");

    // Severe report only inside an open window, lamp lit
    a_severe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.accident_level == LVL_SEVERE |->
            o_out.watching && o_out.lamp_level == LAMP_CRASH)
        else $error("severe report outside window");

    // A dropped impact reports nothing else
    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.crash_ignored |->
            o_out.accident_level == LVL_NONE && o_out.lamp_level == LAMP_NONE)
        else $error("ignored impact with a report");

    a_swing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.largest_swing <= DEG_HALF && o_out.accident_level != 2'd1)
        else $error("swing or level out of range");

endmodule

bind crash_response_monitor crm_checker u_crm_checker (.*);
